// ----- hw/rtl/ffha_pkg.sv -----
// ffha_pkg: shared types and codes for the first-fit heap allocator
// holds the result codes and the command/status bundles between controller and datapath
// no dependencies
package ffha_pkg;

    // result codes
    localparam logic [2:0] RES_OK      = 3'd0;
    localparam logic [2:0] RES_NULL    = 3'd1;
    localparam logic [2:0] RES_NOSPACE = 3'd2;
    localparam logic [2:0] RES_BADPTR  = 3'd3;
    localparam logic [2:0] RES_FULL    = 3'd4;

    // which table a scan walks and what it looks for
    typedef enum logic [1:0] {
        SC_FIT  = 2'd0,
        SC_USED = 2'd1,
        SC_NBR  = 2'd2
    } ffha_scan_t;

    typedef struct packed {
        logic       load;
        logic       decode;
        logic       scan_start;
        logic       scan_step;
        ffha_scan_t scan_sel;
        logic       bad_ptr;
        logic       alloc_hit;
        logic       alloc_top;
        logic       free_upd;
        logic       shift_start;
        logic       sh_used;
        logic       shift_rd;
        logic       shift_wr;
        logic       shift_end;
        logic       finish;
    } ffha_cmd_t;

    typedef struct packed {
        logic early;
        logic is_free;
        logic scan_done;
        logic fit_hit;
        logic used_hit;
        logic exact;
        logic both;
        logic any_nbr;
        logic free_full;
        logic shift_last;
        logic out_ready;
    } ffha_stat_t;

endpackage

// ----- hw/rtl/ffha_ram.sv -----
// ffha_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ffha_ctrl.sv -----
// ffha_ctrl: sequencing state machine of the heap allocator
// depends on ffha_pkg for the command and status bundles
module ffha_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ffha_pkg::ffha_stat_t stat,
    output ffha_pkg::ffha_cmd_t  cmd
);
    import ffha_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_SCAN      = 9'b000000100,
        S_ALLOC_HIT = 9'b000001000,
        S_ALLOC_TOP = 9'b000010000,
        S_FREE_UPD  = 9'b000100000,
        S_SHIFT_RD  = 9'b001000000,
        S_SHIFT_WR  = 9'b010000000,
        S_FINISH    = 9'b100000000
    } ffha_state_t;

    ffha_state_t state_reg, state_next;
    ffha_scan_t  sel_reg, sel_next;
    logic        used_pend_reg, used_pend_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        used_pend_next = used_pend_reg;
        cmd            = '0;
        cmd.scan_sel   = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.early)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_sel   = stat.is_free ? SC_USED : SC_FIT;
                    sel_next       = cmd.scan_sel;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    unique case (sel_reg)
                        SC_FIT:
                        begin
                            state_next = stat.fit_hit ? S_ALLOC_HIT : S_ALLOC_TOP;
                        end
                        SC_USED:
                        begin
                            if (stat.used_hit)
                            begin
                                // found the chunk, now look for free neighbors
                                cmd.scan_start = 1'b1;
                                sel_next       = SC_NBR;
                            end
                            else
                            begin
                                cmd.bad_ptr = 1'b1;
                                state_next  = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FREE_UPD;
                        end
                    endcase
                end
            end
            S_ALLOC_HIT:
            begin
                cmd.alloc_hit = 1'b1;
                if (stat.exact)
                begin
                    cmd.shift_start = 1'b1;
                    used_pend_next  = 1'b0;
                    state_next      = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_ALLOC_TOP:
            begin
                cmd.alloc_top = 1'b1;
                state_next    = S_FINISH;
            end
            S_FREE_UPD:
            begin
                cmd.free_upd = 1'b1;
                priority if (stat.both)
                begin
                    cmd.shift_start = 1'b1;
                    used_pend_next  = 1'b1;
                    state_next      = S_SHIFT_RD;
                end
                else if (stat.free_full)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.shift_start = 1'b1;
                    cmd.sh_used     = 1'b1;
                    used_pend_next  = 1'b0;
                    state_next      = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_last)
                begin
                    cmd.shift_end = 1'b1;
                    if (used_pend_reg)
                    begin
                        cmd.shift_start = 1'b1;
                        cmd.sh_used     = 1'b1;
                        used_pend_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (stat.out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SC_FIT;
            used_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            used_pend_reg <= used_pend_next;
        end
    end

endmodule

// ----- hw/rtl/ffha_dp.sv -----
// ffha_dp: datapath of the heap allocator: free and used tables, counts, top pointer, result
// depends on ffha_pkg and ffha_ram
module ffha_dp #(
    parameter int HEAP_BYTES    = 65536,
    parameter int TABLE_ENTRIES = 64,
    parameter int HEADER_BYTES  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 action,
    input  logic [16:0]          request_bytes,
    input  logic [15:0]          user_offset,
    input  ffha_pkg::ffha_cmd_t  cmd,
    output ffha_pkg::ffha_stat_t stat,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [15:0]          granted_offset,
    output logic [2:0]           status,
    output logic [6:0]           used_count,
    output logic [6:0]           free_count
);
    import ffha_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = $clog2(HEAP_BYTES + 131072) + 1;
    localparam int DW = 2 * AW;
    localparam logic [AW-1:0] HDR  = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] HEAP = AW'(HEAP_BYTES);
    localparam logic [CW-1:0] TBL  = CW'(TABLE_ENTRIES);

    // request
    logic          act_reg, act_next;
    logic [16:0]   reqb_reg, reqb_next;
    logic [15:0]   uoff_reg, uoff_next;
    // table occupancy and heap top
    logic [CW-1:0] fn_reg, fn_next, un_reg, un_next;
    logic [AW-1:0] top_reg, top_next;
    logic [2:0]    res_reg, res_next;
    logic [15:0]   grant_reg, grant_next;
    // scan pipeline
    logic [IW-1:0] idx_reg, idx_next, chk_addr_reg, chk_addr_next;
    logic [CW-1:0] left_reg, left_next;
    logic          chk_vld_reg, chk_vld_next;
    // captured entries
    logic [IW-1:0] hit_addr_reg, hit_addr_next;
    logic [AW-1:0] hit_start_reg, hit_start_next, hit_size_reg, hit_size_next;
    logic [IW-1:0] u_addr_reg, u_addr_next;
    logic [AW-1:0] c_start_reg, c_start_next, c_size_reg, c_size_next;
    logic          l_found_reg, l_found_next, r_found_reg, r_found_next;
    logic [IW-1:0] l_addr_reg, l_addr_next, r_addr_reg, r_addr_next;
    logic [AW-1:0] l_start_reg, l_start_next, l_size_reg, l_size_next;
    logic [AW-1:0] r_size_reg, r_size_next;
    // removal sweep
    logic          sh_used_reg, sh_used_next;
    logic [IW-1:0] sh_addr_reg, sh_addr_next;
    // result register
    logic          rsp_valid_reg, rsp_valid_next;
    logic [15:0]   o_grant_reg, o_grant_next;
    logic [2:0]    o_status_reg, o_status_next;
    logic [6:0]    o_used_reg, o_used_next, o_free_reg, o_free_next;

    // memories
    logic          f_we, u_we;
    logic [IW-1:0] f_waddr, u_waddr, f_raddr, u_raddr;
    logic [DW-1:0] f_wdata, u_wdata, f_rdata, u_rdata;
    logic [AW-1:0] f_rd_start, f_rd_size, u_rd_start;

    logic [AW-1:0] need, rem, c_end, top_sum;
    logic          top_fail, exhausted, fit_now, used_now, l_now, r_now;
    logic [IW-1:0] keep_addr, drop_addr;
    logic [CW-1:0] sh_cnt, scan_n, scan_n_m1;

    ffha_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    ffha_ram #(.WIDTH(DW), .DEPTH(TABLE_ENTRIES)) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    assign f_rd_start = f_rdata[DW-1:AW];
    assign f_rd_size  = f_rdata[AW-1:0];
    assign u_rd_start = u_rdata[DW-1:AW];

    assign need      = AW'(reqb_reg) + HDR;
    assign rem       = hit_size_reg - need;
    assign c_end     = c_start_reg + HDR + c_size_reg;
    assign top_sum   = top_reg + need;
    assign top_fail  = top_sum > HEAP;
    assign exhausted = (left_reg == '0) && !chk_vld_reg;

    assign fit_now  = chk_vld_reg && (cmd.scan_sel == SC_FIT) && (f_rd_size >= need);
    assign used_now = chk_vld_reg && (cmd.scan_sel == SC_USED)
                      && (u_rd_start + HDR == AW'(uoff_reg));
    assign l_now    = chk_vld_reg && (cmd.scan_sel == SC_NBR) && !l_found_reg
                      && (f_rd_start + HDR + f_rd_size == c_start_reg);
    assign r_now    = chk_vld_reg && (cmd.scan_sel == SC_NBR) && !l_now && !r_found_reg
                      && (f_rd_start == c_end);

    // larger physical slot is the more recent list position
    assign keep_addr = (l_addr_reg > r_addr_reg) ? l_addr_reg : r_addr_reg;
    assign drop_addr = (l_addr_reg > r_addr_reg) ? r_addr_reg : l_addr_reg;
    assign sh_cnt    = sh_used_reg ? un_reg : fn_reg;
    // the neighbor scan is started from within the used scan, so only a start
    // outside a scan walks the used table
    assign scan_n    = ((cmd.scan_sel == SC_USED) && !cmd.scan_step) ? un_reg : fn_reg;
    assign scan_n_m1 = scan_n - CW'(1);

    always_comb
    begin
        stat            = '0;
        stat.early      = act_reg ? (uoff_reg == '0) : ((reqb_reg == '0) || (un_reg >= TBL));
        stat.is_free    = act_reg;
        stat.fit_hit    = fit_now;
        stat.used_hit   = used_now;
        stat.exact      = (rem == '0);
        stat.both       = l_found_reg && r_found_reg;
        stat.any_nbr    = l_found_reg || r_found_reg;
        stat.free_full  = !l_found_reg && !r_found_reg && (fn_reg >= TBL);
        stat.shift_last = (CW'(sh_addr_reg) + CW'(1)) >= sh_cnt;
        stat.out_ready  = !rsp_valid_reg || !rsp_stall;
        unique case (cmd.scan_sel)
            SC_FIT:  stat.scan_done = fit_now || exhausted;
            SC_USED: stat.scan_done = used_now || exhausted;
            SC_NBR:  stat.scan_done = ((l_found_reg || l_now) && (r_found_reg || r_now))
                                      || exhausted;
            default: stat.scan_done = exhausted;
        endcase
    end

    // memory ports
    always_comb
    begin
        f_raddr = (cmd.shift_rd && !sh_used_reg) ? (sh_addr_reg + IW'(1)) : idx_reg;
        u_raddr = (cmd.shift_rd && sh_used_reg) ? (sh_addr_reg + IW'(1)) : idx_reg;
        f_we    = 1'b0;
        f_waddr = hit_addr_reg;
        f_wdata = {hit_start_reg + need, rem};
        u_we    = 1'b0;
        u_waddr = un_reg[IW-1:0];
        u_wdata = {hit_start_reg, AW'(reqb_reg)};
        if (cmd.alloc_hit)
        begin
            u_we = 1'b1;
            f_we = (rem != '0);
        end
        if (cmd.alloc_top && !top_fail)
        begin
            u_we    = 1'b1;
            u_wdata = {top_reg, AW'(reqb_reg)};
        end
        if (cmd.free_upd)
        begin
            priority if (l_found_reg && r_found_reg)
            begin
                f_we    = 1'b1;
                f_waddr = keep_addr;
                f_wdata = {l_start_reg, l_size_reg + HDR + c_size_reg + HDR + r_size_reg};
            end
            else if (l_found_reg)
            begin
                f_we    = 1'b1;
                f_waddr = l_addr_reg;
                f_wdata = {l_start_reg, l_size_reg + HDR + c_size_reg};
            end
            else if (r_found_reg)
            begin
                f_we    = 1'b1;
                f_waddr = r_addr_reg;
                f_wdata = {c_start_reg, c_size_reg + HDR + r_size_reg};
            end
            else if (fn_reg < TBL)
            begin
                f_we    = 1'b1;
                f_waddr = fn_reg[IW-1:0];
                f_wdata = {c_start_reg, c_size_reg};
            end
        end
        if (cmd.shift_wr)
        begin
            if (sh_used_reg)
            begin
                u_we    = 1'b1;
                u_waddr = sh_addr_reg;
                u_wdata = u_rdata;
            end
            else
            begin
                f_we    = 1'b1;
                f_waddr = sh_addr_reg;
                f_wdata = f_rdata;
            end
        end
    end

    always_comb
    begin
        act_next       = act_reg;
        reqb_next      = reqb_reg;
        uoff_next      = uoff_reg;
        fn_next        = fn_reg;
        un_next        = un_reg;
        top_next       = top_reg;
        res_next       = res_reg;
        grant_next     = grant_reg;
        idx_next       = idx_reg;
        chk_addr_next  = chk_addr_reg;
        left_next      = left_reg;
        chk_vld_next   = chk_vld_reg;
        hit_addr_next  = hit_addr_reg;
        hit_start_next = hit_start_reg;
        hit_size_next  = hit_size_reg;
        u_addr_next    = u_addr_reg;
        c_start_next   = c_start_reg;
        c_size_next    = c_size_reg;
        l_found_next   = l_found_reg;
        r_found_next   = r_found_reg;
        l_addr_next    = l_addr_reg;
        r_addr_next    = r_addr_reg;
        l_start_next   = l_start_reg;
        l_size_next    = l_size_reg;
        r_size_next    = r_size_reg;
        sh_used_next   = sh_used_reg;
        sh_addr_next   = sh_addr_reg;
        rsp_valid_next = rsp_valid_reg;
        o_grant_next   = o_grant_reg;
        o_status_next  = o_status_reg;
        o_used_next    = o_used_reg;
        o_free_next    = o_free_reg;

        if (cmd.load)
        begin
            act_next  = action;
            reqb_next = request_bytes;
            uoff_next = user_offset;
        end

        if (cmd.decode)
        begin
            grant_next = '0;
            if (!stat.early)
            begin
                res_next = RES_OK;
            end
            else if (act_reg || (reqb_reg == '0))
            begin
                res_next = RES_NULL;
            end
            else
            begin
                res_next = RES_FULL;
            end
        end

        // scan: one read issued and one entry checked per cycle
        if (cmd.scan_step)
        begin
            if (left_reg != '0)
            begin
                idx_next      = idx_reg - IW'(1);
                left_next     = left_reg - CW'(1);
                chk_addr_next = idx_reg;
                chk_vld_next  = 1'b1;
            end
            else
            begin
                chk_vld_next = 1'b0;
            end
            if (fit_now)
            begin
                hit_addr_next  = chk_addr_reg;
                hit_start_next = f_rd_start;
                hit_size_next  = f_rd_size;
            end
            if (used_now)
            begin
                u_addr_next  = chk_addr_reg;
                c_start_next = u_rd_start;
                c_size_next  = u_rdata[AW-1:0];
            end
            if (l_now)
            begin
                l_found_next = 1'b1;
                l_addr_next  = chk_addr_reg;
                l_start_next = f_rd_start;
                l_size_next  = f_rd_size;
            end
            if (r_now)
            begin
                r_found_next = 1'b1;
                r_addr_next  = chk_addr_reg;
                r_size_next  = f_rd_size;
            end
        end
        if (cmd.scan_start)
        begin
            idx_next     = scan_n_m1[IW-1:0];
            left_next    = scan_n;
            chk_vld_next = 1'b0;
            l_found_next = 1'b0;
            r_found_next = 1'b0;
        end

        if (cmd.bad_ptr)
        begin
            res_next = RES_BADPTR;
        end

        if (cmd.alloc_hit)
        begin
            un_next    = un_reg + CW'(1);
            grant_next = 16'(hit_start_reg + HDR);
        end

        if (cmd.alloc_top)
        begin
            if (top_fail)
            begin
                res_next = RES_NOSPACE;
            end
            else
            begin
                un_next    = un_reg + CW'(1);
                grant_next = 16'(top_reg + HDR);
                top_next   = top_sum;
            end
        end

        if (cmd.free_upd && !l_found_reg && !r_found_reg)
        begin
            if (fn_reg >= TBL)
            begin
                res_next = RES_FULL;
            end
            else
            begin
                fn_next = fn_reg + CW'(1);
            end
        end

        if (cmd.shift_wr)
        begin
            sh_addr_next = sh_addr_reg + IW'(1);
        end
        if (cmd.shift_end)
        begin
            if (sh_used_reg)
            begin
                un_next = un_reg - CW'(1);
            end
            else
            begin
                fn_next = fn_reg - CW'(1);
            end
        end
        if (cmd.shift_start)
        begin
            sh_used_next = cmd.sh_used;
            if (cmd.sh_used)
            begin
                sh_addr_next = u_addr_reg;
            end
            else
            begin
                sh_addr_next = act_reg ? drop_addr : hit_addr_reg;
            end
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
            o_grant_next   = grant_reg;
            o_status_next  = res_reg;
            o_used_next    = 7'(un_reg);
            o_free_next    = 7'(fn_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_reg        <= '0;
            un_reg        <= '0;
            top_reg       <= '0;
            left_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            l_found_reg   <= 1'b0;
            r_found_reg   <= 1'b0;
            sh_used_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fn_reg        <= fn_next;
            un_reg        <= un_next;
            top_reg       <= top_next;
            left_reg      <= left_next;
            chk_vld_reg   <= chk_vld_next;
            l_found_reg   <= l_found_next;
            r_found_reg   <= r_found_next;
            sh_used_reg   <= sh_used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        reqb_reg      <= reqb_next;
        uoff_reg      <= uoff_next;
        res_reg       <= res_next;
        grant_reg     <= grant_next;
        idx_reg       <= idx_next;
        chk_addr_reg  <= chk_addr_next;
        hit_addr_reg  <= hit_addr_next;
        hit_start_reg <= hit_start_next;
        hit_size_reg  <= hit_size_next;
        u_addr_reg    <= u_addr_next;
        c_start_reg   <= c_start_next;
        c_size_reg    <= c_size_next;
        l_addr_reg    <= l_addr_next;
        r_addr_reg    <= r_addr_next;
        l_start_reg   <= l_start_next;
        l_size_reg    <= l_size_next;
        r_size_reg    <= r_size_next;
        sh_addr_reg   <= sh_addr_next;
        o_grant_reg   <= o_grant_next;
        o_status_reg  <= o_status_next;
        o_used_reg    <= o_used_next;
        o_free_reg    <= o_free_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign granted_offset = o_grant_reg;
    assign status         = o_status_reg;
    assign used_count     = o_used_reg;
    assign free_count     = o_free_reg;

endmodule

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// first_fit_heap_allocator: top level, joins the controller and the datapath
// depends on ffha_pkg, ffha_ctrl, ffha_dp (which holds two ffha_ram tables)
//
// First-fit heap allocator with coalescing. One transaction at a time: a
// request (action 0 allocate request_bytes, action 1 free user_offset) gives
// exactly one response transaction with the granted user offset, a status
// code and the used and free table fill counts after the request. The free
// and used tables each sit in a RAM with one write port and one registered
// read port, kept as a dense prefix whose fill count marks the valid entries,
// so no clearing pass is needed after reset. A scan walks those RAMs one entry
// per cycle. An allocation scans the free entries, and an exact fit then
// removes a free entry with a sweep that moves each later entry down; a free
// scans the used table for the pointer and then the free table for neighbors,
// and sweeps entries out of the free table (two-sided merge) and out of the
// used table when they are removed. Rejected requests (zero size, null
// pointer, full used table) answer without a scan. The response sits in
// an output register, so a stalled response holds its payload while the
// block finishes the request in flight.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES    = 65536,
    parameter int TABLE_ENTRIES = 64,
    parameter int HEADER_BYTES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        action,
    input  logic [16:0] request_bytes,
    input  logic [15:0] user_offset,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [15:0] granted_offset,
    output logic [2:0]  status,
    output logic [6:0]  used_count,
    output logic [6:0]  free_count
);
    import ffha_pkg::*;

    ffha_cmd_t  cmd;
    ffha_stat_t stat;

    // sequencing: decode, scan, table update, entry removal sweeps
    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tables, counters, top pointer and response register
    ffha_dp #(
        .HEAP_BYTES    (HEAP_BYTES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (action),
        .request_bytes  (request_bytes),
        .user_offset    (user_offset),
        .cmd            (cmd),
        .stat           (stat),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .granted_offset (granted_offset),
        .status         (status),
        .used_count     (used_count),
        .free_count     (free_count)
    );

endmodule

// ----- hw/rtl/ffha_checker.sv -----
// ffha_checker: port-level assertions for the heap allocator, bound to the top level
// depends on ffha_pkg and first_fit_heap_allocator
module ffha_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [15:0] granted_offset,
    input logic [2:0]  status,
    input logic [6:0]  used_count,
    input logic [6:0]  free_count
);
    import ffha_pkg::*;

    localparam logic [6:0] CAP = 7'(TABLE_ENTRIES);

    // one request in flight: an accepted request blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another is in flight");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(granted_offset) && $stable(status))
        else $error("stalled response changed");

    // failed requests grant nothing
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != RES_OK) |-> granted_offset == '0)
        else $error("offset granted on a failed request");

    // fill counts in a response never exceed the table size (checked for tables up to 127 entries)
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (TABLE_ENTRIES > 127) || ((used_count <= CAP) && (free_count <= CAP)))
        else $error("table count beyond table size");

endmodule

bind first_fit_heap_allocator ffha_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ffha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .granted_offset (granted_offset),
    .status         (status),
    .used_count     (used_count),
    .free_count     (free_count)
);
